FILE: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms used by the port checker module.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define CSD_ASSERT_IMPL(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define CSD_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: rtl/cartsd_pkg.sv
// ----------------------------------------------------------------------------
// Cartridge SD register interface package
// Types, register offsets, command codes and constants shared by the block.
// ----------------------------------------------------------------------------
package cartsd_pkg;

   localparam int unsigned BUFFER_BYTES_DEF     = 8192;
   localparam int unsigned ROM_WINDOW_BYTES_DEF = 67108864;

   localparam int REQ_TDATA_W = 80;
   localparam int RSP_TDATA_W = 152;
   localparam int SPAN_W      = 41;  // sector or block count times 512
   localparam int END_W       = 42;  // sum of two spans
   localparam int MADDR_W     = 29;

   // Register byte offsets
   localparam logic [15:0] OFS_STATUS = 16'h0000;
   localparam logic [15:0] OFS_DATA0  = 16'h0004;
   localparam logic [15:0] OFS_DATA1  = 16'h0008;
   localparam logic [15:0] OFS_ID     = 16'h000C;
   localparam logic [15:0] OFS_UNLOCK = 16'h0010;

   // Command codes written to the status offset
   localparam logic [31:0] CMD_CFG_GET  = 32'h0000_0063;
   localparam logic [31:0] CMD_CFG_SET  = 32'h0000_0043;
   localparam logic [31:0] CMD_INIT     = 32'h0000_0069;
   localparam logic [31:0] CMD_SECTOR   = 32'h0000_0049;
   localparam logic [31:0] CMD_SD_READ  = 32'h0000_0073;
   localparam logic [31:0] CMD_SD_WRITE = 32'h0000_0053;

   // Arguments of the config and init commands
   localparam logic [31:0] CFG_ROM_WRITE = 32'd1;
   localparam logic [31:0] CFG_QUERY_A   = 32'd3;
   localparam logic [31:0] CFG_QUERY_B   = 32'd6;
   localparam logic [31:0] INIT_NOP      = 32'd0;
   localparam logic [31:0] INIT_CARD     = 32'd1;
   localparam logic [31:0] INIT_SWAP_ON  = 32'd4;
   localparam logic [31:0] INIT_SWAP_OFF = 32'd5;

   // Unlock sequence
   localparam logic [31:0] KEY_LOCK   = 32'hFFFF_FFFF;
   localparam logic [31:0] KEY_FIRST  = 32'h5F55_4E4C;
   localparam logic [31:0] KEY_SECOND = 32'h4F43_4B5F;

   localparam logic [31:0] ID_WORD    = 32'h5343_7632;
   localparam logic [31:0] ERR_STATUS = 32'h4000_0000;
   localparam logic [31:0] BUF_BASE   = 32'h1FFE_0000;
   localparam logic [31:0] ROM_BASE   = 32'h1000_0000;

   // Configuration register indexes
   localparam logic CSR_CARD_PRESENT = 1'b0;
   localparam logic CSR_CARD_SIZE    = 1'b1;

   typedef struct packed {
      logic        is_write;
      logic [15:0] address;
      logic [31:0] value;    // write data already masked
   } req_type;

   typedef struct packed {
      logic [31:0]        read_data;
      logic               xfer_request;
      logic               xfer_to_card;
      logic [SPAN_W-1:0]  xfer_byte_offset;
      logic [SPAN_W-1:0]  xfer_length_bytes;
      logic [MADDR_W-1:0] xfer_mem_addr;
      logic               xfer_byteswap;
   } rsp_type;

   typedef struct packed {
      logic               ok;
      logic [SPAN_W-1:0]  byte_offset;
      logic [SPAN_W-1:0]  length;
      logic [MADDR_W-1:0] mem_addr;
   } xfer_type;

endpackage

FILE: rtl/cart_sd_register_interface_core.sv
// ----------------------------------------------------------------------------
// Cartridge SD register interface core
// Register bus front end with unlock sequence, command decode and SD checks.
// ----------------------------------------------------------------------------
// Each request transfer is one bus access (read or masked write) and yields
// exactly one response transfer. The block sustains one access per clock
// while the response side is ready: an access is held in the input register,
// is decoded and applied to the register state in a single combinational
// pass and lands in the response register, from which its response is
// offered until the response side takes it. The response register lets a
// new request be taken while an earlier response still waits. An SD read
// or write command that passes the card bounds and memory window checks
// reports the transfer on the response (tuser high); the transfer itself is
// carried out elsewhere. Configuration writes take effect at once and are
// meant to be issued only while no access is in flight.
// ----------------------------------------------------------------------------
module cart_sd_register_interface_core
   import cartsd_pkg::*;
#(
   parameter int unsigned BUFFER_BYTES     = BUFFER_BYTES_DEF,
   parameter int unsigned ROM_WINDOW_BYTES = ROM_WINDOW_BYTES_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   // address[15:0], write_data[47:16], write_mask[79:48]
   input  logic [REQ_TDATA_W-1:0] req_tdata,
   // command[0]: 0 read, 1 write
   input  logic                   req_tuser,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   // read_data[31:0], xfer_to_card[32], xfer_byte_offset[73:33],
   // xfer_length_bytes[114:74], xfer_mem_addr[143:115], xfer_byteswap[144],
   // zero fill [151:145]
   output logic [RSP_TDATA_W-1:0] rsp_tdata,
   // xfer_request[0]
   output logic                   rsp_tuser,
   input  logic                   csr_we,
   input  logic                   csr_index,
   input  logic [31:0]            csr_wdata
);

   logic    in_valid_ff, in_valid_in;
   req_type in_item_ff;
   logic    out_valid_ff, out_valid_in;
   rsp_type out_item_ff;
   rsp_type result;
   logic    advance;
   logic    req_fire;

   // The access in the input register moves on whenever the response
   // register is empty or its content is taken in the same cycle.
   assign advance    = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;
   assign req_fire   = req_tvalid && req_tready;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_fire) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
      out_valid_in = out_valid_ff;
      if (advance) begin
         out_valid_in = 1'b1;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Payload registers; the mask is applied on the way in.
   always_ff @(posedge clock) begin
      if (req_fire) begin
         in_item_ff.is_write <= req_tuser;
         in_item_ff.address  <= req_tdata[15:0];
         in_item_ff.value    <= req_tdata[47:16] & req_tdata[79:48];
      end
      if (advance) begin
         out_item_ff <= result;
      end
   end

   cartsd_regfile #(
      .BUFFER_BYTES     (BUFFER_BYTES),
      .ROM_WINDOW_BYTES (ROM_WINDOW_BYTES)
   ) u_regfile (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .fire      (advance),
      .req       (in_item_ff),
      .rsp       (result)
   );

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tuser  = out_item_ff.xfer_request;
   assign rsp_tdata  = {7'b0,
                        out_item_ff.xfer_byteswap,
                        out_item_ff.xfer_mem_addr,
                        out_item_ff.xfer_length_bytes,
                        out_item_ff.xfer_byte_offset,
                        out_item_ff.xfer_to_card,
                        out_item_ff.read_data};

endmodule

FILE: rtl/cartsd_xfer_check.sv
// ----------------------------------------------------------------------------
// SD transfer check
// Card bounds and memory window checks for an SD read or write command.
// ----------------------------------------------------------------------------
module cartsd_xfer_check
   import cartsd_pkg::*;
#(
   parameter int unsigned BUFFER_BYTES     = BUFFER_BYTES_DEF,
   parameter int unsigned ROM_WINDOW_BYTES = ROM_WINDOW_BYTES_DEF
) (
   input  logic [31:0] card_sector,
   input  logic [31:0] data_zero,
   input  logic [31:0] data_one,
   input  logic [31:0] card_size,
   input  logic        card_open,
   output xfer_type    xfer
);

   localparam logic [END_W-1:0] BufLimit = END_W'(BUF_BASE) + END_W'(BUFFER_BYTES);
   localparam logic [END_W-1:0] RomLimit = END_W'(ROM_BASE) + END_W'(ROM_WINDOW_BYTES);

   logic [SPAN_W-1:0]  offset;
   logic [SPAN_W-1:0]  length;
   logic [MADDR_W-1:0] maddr;
   logic [END_W-1:0]   card_end;
   logic [END_W-1:0]   mem_end;
   logic               in_card;
   logic               in_buf;
   logic               in_rom;

   assign offset   = {card_sector, 9'b0};
   assign length   = {data_one, 9'b0};
   assign maddr    = data_zero[MADDR_W-1:0];
   assign card_end = END_W'(offset) + END_W'(length);
   assign mem_end  = END_W'(maddr) + END_W'(length);

   assign in_card = card_end <= END_W'(card_size);
   assign in_buf  = (32'(maddr) >= BUF_BASE) && (mem_end < BufLimit);
   assign in_rom  = (32'(maddr) >= ROM_BASE) && (mem_end < RomLimit);

   assign xfer.ok          = in_card && (in_buf || in_rom) && card_open;
   assign xfer.byte_offset = offset;
   assign xfer.length      = length;
   assign xfer.mem_addr    = maddr;

endmodule

FILE: rtl/cartsd_regfile.sv
// ----------------------------------------------------------------------------
// Register file and command decoder
// Holds the block state, decodes one access and forms its result.
// ----------------------------------------------------------------------------
module cartsd_regfile
   import cartsd_pkg::*;
#(
   parameter int unsigned BUFFER_BYTES     = BUFFER_BYTES_DEF,
   parameter int unsigned ROM_WINDOW_BYTES = ROM_WINDOW_BYTES_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_we,
   input  logic        csr_index,
   input  logic [31:0] csr_wdata,
   input  logic        fire,
   input  req_type     req,
   output rsp_type     rsp
);

   logic        card_present_ff;
   logic [31:0] card_size_ff;
   logic [31:0] status_ff, status_in;
   logic [31:0] data0_ff, data0_in;
   logic [31:0] data1_ff, data1_in;
   logic [31:0] sector_ff, sector_in;
   logic        rom_we_ff, rom_we_in;
   logic        swap_ff, swap_in;
   logic        unlocked_ff, unlocked_in;
   logic        key1_ff, key1_in;
   logic        open_ff, open_in;
   xfer_type    xfer;

   cartsd_xfer_check #(
      .BUFFER_BYTES     (BUFFER_BYTES),
      .ROM_WINDOW_BYTES (ROM_WINDOW_BYTES)
   ) u_xfer_check (
      .card_sector (sector_ff),
      .data_zero   (data0_ff),
      .data_one    (data1_ff),
      .card_size   (card_size_ff),
      .card_open   (open_ff),
      .xfer        (xfer)
   );

   always_comb begin
      status_in   = status_ff;
      data0_in    = data0_ff;
      data1_in    = data1_ff;
      sector_in   = sector_ff;
      rom_we_in   = rom_we_ff;
      swap_in     = swap_ff;
      unlocked_in = unlocked_ff;
      key1_in     = key1_ff;
      open_in     = open_ff;
      rsp         = '0;

      if (!req.is_write) begin
         if (unlocked_ff) begin
            unique case (req.address)
               OFS_STATUS: rsp.read_data = status_ff;
               OFS_DATA0:  rsp.read_data = data0_ff;
               OFS_DATA1:  rsp.read_data = data1_ff;
               OFS_ID:     rsp.read_data = ID_WORD;
               default:    rsp.read_data = '0;
            endcase
         end
      end else if (req.address == OFS_UNLOCK) begin
         priority if (req.value == KEY_LOCK) begin
            unlocked_in = 1'b0;
         end else if (req.value == KEY_FIRST) begin
            key1_in = 1'b1;
         end else if (req.value == KEY_SECOND) begin
            if (key1_ff) begin
               unlocked_in = 1'b1;
               key1_in     = 1'b0;
            end
         end else begin
            key1_in = 1'b0;
         end
      end else if (unlocked_ff) begin
         if (req.address == OFS_DATA0) begin
            data0_in = req.value;
         end else if (req.address == OFS_DATA1) begin
            data1_in = req.value;
         end else if (req.address == OFS_STATUS) begin
            status_in = '0;
            unique case (req.value)
               CMD_CFG_GET: begin
                  priority if (data0_ff == CFG_ROM_WRITE) begin
                     data1_in = 32'(rom_we_ff);
                  end else if (data0_ff == CFG_QUERY_A || data0_ff == CFG_QUERY_B) begin
                     data1_in = '0;
                  end else begin
                     status_in = ERR_STATUS;
                  end
               end
               CMD_CFG_SET: begin
                  if (data0_ff == CFG_ROM_WRITE) begin
                     data1_in  = 32'(rom_we_ff);
                     rom_we_in = (data1_ff != '0);
                  end else begin
                     status_in = ERR_STATUS;
                  end
               end
               CMD_INIT: begin
                  priority if (data1_ff == INIT_NOP) begin
                     status_in = '0;
                  end else if (data1_ff == INIT_CARD) begin
                     open_in   = card_present_ff;
                     status_in = card_present_ff ? '0 : ERR_STATUS;
                  end else if (data1_ff == INIT_SWAP_ON) begin
                     swap_in = 1'b1;
                  end else if (data1_ff == INIT_SWAP_OFF) begin
                     swap_in = 1'b0;
                  end else begin
                     status_in = ERR_STATUS;
                  end
               end
               CMD_SECTOR: begin
                  sector_in = data0_ff;
               end
               CMD_SD_READ, CMD_SD_WRITE: begin
                  if (xfer.ok) begin
                     rsp.xfer_request      = 1'b1;
                     rsp.xfer_to_card      = (req.value == CMD_SD_WRITE);
                     rsp.xfer_byte_offset  = xfer.byte_offset;
                     rsp.xfer_length_bytes = xfer.length;
                     rsp.xfer_mem_addr     = xfer.mem_addr;
                     rsp.xfer_byteswap     = (req.value == CMD_SD_READ) && swap_ff;
                  end else begin
                     status_in = ERR_STATUS;
                  end
               end
               default: status_in = ERR_STATUS;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         card_present_ff <= 1'b0;
         card_size_ff    <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_CARD_PRESENT: card_present_ff <= csr_wdata[0];
            CSR_CARD_SIZE:    card_size_ff    <= csr_wdata;
            default:          card_size_ff    <= card_size_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         status_ff   <= '0;
         data0_ff    <= '0;
         data1_ff    <= '0;
         sector_ff   <= '0;
         rom_we_ff   <= 1'b0;
         swap_ff     <= 1'b0;
         unlocked_ff <= 1'b0;
         key1_ff     <= 1'b0;
         open_ff     <= 1'b0;
      end else if (fire) begin
         status_ff   <= status_in;
         data0_ff    <= data0_in;
         data1_ff    <= data1_in;
         sector_ff   <= sector_in;
         rom_we_ff   <= rom_we_in;
         swap_ff     <= swap_in;
         unlocked_ff <= unlocked_in;
         key1_ff     <= key1_in;
         open_ff     <= open_in;
      end
   end

endmodule

FILE: rtl/cartsd_checker.sv
// ----------------------------------------------------------------------------
// Port checker
// Watches the response channel of the core for consistent transfer results.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module cartsd_checker
   import cartsd_pkg::*;
(
   input logic                   clock,
   input logic                   reset,
   input logic                   rsp_tvalid,
   input logic                   rsp_tready,
   input logic [RSP_TDATA_W-1:0] rsp_tdata,
   input logic                   rsp_tuser
);

   // A stalled response stays offered.
   `CSD_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid, "response dropped while stalled")

   // Without a transfer request every transfer field is zero.
   `CSD_ASSERT_IMPL(a_xfer_zero, clock, reset, rsp_tvalid && !rsp_tuser, rsp_tdata[RSP_TDATA_W-1:32] == '0, "transfer fields set without a request")

   // A transfer request never carries read data.
   `CSD_ASSERT_IMPL(a_xfer_no_read, clock, reset, rsp_tvalid && rsp_tuser, rsp_tdata[31:0] == '0, "read data on a transfer response")

   // Card offset and length are whole sectors.
   `CSD_ASSERT_IMPL(a_xfer_sector, clock, reset, rsp_tvalid && rsp_tuser, rsp_tdata[41:33] == '0 && rsp_tdata[82:74] == '0, "transfer not sector aligned")

   // Byte swapping only applies to card-to-memory transfers.
   `CSD_ASSERT_IMPL(a_swap_dir, clock, reset, rsp_tvalid && rsp_tuser && rsp_tdata[32], !rsp_tdata[144], "byte swap on a memory-to-card transfer")

endmodule

bind cart_sd_register_interface_core cartsd_checker u_cartsd_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

FILE: dv/cartsd_access_checker.sv
// ----------------------------------------------------------------------------
// Cartridge SD register access checker
// Watches the request, response and configuration ports, predicts each
// response from its own copy of the register state and compares it.
// ----------------------------------------------------------------------------
module cartsd_access_checker
   import cartsd_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   input  logic                   req_tready,
   input  logic [REQ_TDATA_W-1:0] req_tdata,
   input  logic                   req_tuser,
   input  logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   input  logic [RSP_TDATA_W-1:0] rsp_tdata,
   input  logic                   rsp_tuser,
   input  logic                   csr_we,
   input  logic                   csr_index,
   input  logic [31:0]            csr_wdata,
   output int                     errors,
   output int                     outstanding
);

   // Configuration copy.
   logic        card_present_q;
   logic [31:0] card_size_q;

   // Register state copy.
   logic [31:0] status_q;
   logic [31:0] data0_q;
   logic [31:0] data1_q;
   logic [31:0] sector_q;
   logic        rom_we_q;
   logic        swap_q;
   logic        unlocked_q;
   logic        key_armed_q;
   logic        card_open_q;

   rsp_type expected_responses[$];

   // Applies one bus access to the state copy and returns its response.
   function automatic rsp_type decode_access(input logic is_wr, input logic [15:0] ofs,
                                             input logic [31:0] v);
      rsp_type     res;
      logic [63:0] card_ofs;
      logic [63:0] span;
      logic [63:0] maddr;
      logic        buf_ok;
      logic        rom_ok;
      logic        keep;
      res = '0;
      if (!is_wr) begin
         if (unlocked_q) begin
            case (ofs)
               OFS_STATUS: res.read_data = status_q;
               OFS_DATA0:  res.read_data = data0_q;
               OFS_DATA1:  res.read_data = data1_q;
               OFS_ID:     res.read_data = ID_WORD;
               default:    ;
            endcase
         end
         return res;
      end
      if (ofs == OFS_UNLOCK) begin
         // Locking leaves a pending first key armed.
         if (v == KEY_LOCK) unlocked_q = 1'b0;
         else if (v == KEY_FIRST) key_armed_q = 1'b1;
         else if (v == KEY_SECOND) begin
            if (key_armed_q) begin
               unlocked_q  = 1'b1;
               key_armed_q = 1'b0;
            end
         end else key_armed_q = 1'b0;
         return res;
      end
      if (!unlocked_q) return res;
      case (ofs)
         OFS_DATA0: data0_q = v;
         OFS_DATA1: data1_q = v;
         OFS_STATUS: begin
            status_q = '0;
            case (v)
               CMD_CFG_GET: begin
                  if (data0_q == CFG_ROM_WRITE) data1_q = {31'b0, rom_we_q};
                  else if (data0_q == CFG_QUERY_A || data0_q == CFG_QUERY_B) data1_q = '0;
                  else status_q = ERR_STATUS;
               end
               CMD_CFG_SET: begin
                  if (data0_q == CFG_ROM_WRITE) begin
                     keep     = (data1_q != 0);
                     data1_q  = {31'b0, rom_we_q};
                     rom_we_q = keep;
                  end else status_q = ERR_STATUS;
               end
               CMD_INIT: begin
                  case (data1_q)
                     INIT_NOP: ;
                     INIT_CARD: begin
                        card_open_q = card_present_q;
                        if (!card_present_q) status_q = ERR_STATUS;
                     end
                     INIT_SWAP_ON:  swap_q = 1'b1;
                     INIT_SWAP_OFF: swap_q = 1'b0;
                     default:       status_q = ERR_STATUS;
                  endcase
               end
               CMD_SECTOR: sector_q = data0_q;
               CMD_SD_READ, CMD_SD_WRITE: begin
                  // Wide sums, so neither bound check can wrap.
                  card_ofs = 64'(sector_q) << 9;
                  span     = 64'(data1_q) << 9;
                  maddr    = 64'(data0_q[MADDR_W-1:0]);
                  buf_ok   = maddr >= 64'(BUF_BASE) &&
                             maddr + span < 64'(BUF_BASE) + 64'(BUFFER_BYTES_DEF);
                  rom_ok   = maddr >= 64'(ROM_BASE) &&
                             maddr + span < 64'(ROM_BASE) + 64'(ROM_WINDOW_BYTES_DEF);
                  if (card_ofs + span > 64'(card_size_q) || !(buf_ok || rom_ok) ||
                      !card_open_q) begin
                     status_q = ERR_STATUS;
                  end else begin
                     res.xfer_request      = 1'b1;
                     res.xfer_to_card      = (v == CMD_SD_WRITE);
                     res.xfer_byte_offset  = card_ofs[SPAN_W-1:0];
                     res.xfer_length_bytes = span[SPAN_W-1:0];
                     res.xfer_mem_addr     = maddr[MADDR_W-1:0];
                     res.xfer_byteswap     = (v == CMD_SD_READ) && swap_q;
                  end
               end
               default: status_q = ERR_STATUS;
            endcase
         end
         default: ;
      endcase
      return res;
   endfunction

   function automatic void check_field(input string name, input logic [63:0] want,
                                       input logic [63:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
         errors++;
      end
   endfunction

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         card_present_q = 1'b0;
         card_size_q    = '0;
         status_q       = '0;
         data0_q        = '0;
         data1_q        = '0;
         sector_q       = '0;
         rom_we_q       = 1'b0;
         swap_q         = 1'b0;
         unlocked_q     = 1'b0;
         key_armed_q    = 1'b0;
         card_open_q    = 1'b0;
         expected_responses.delete();
      end else begin
         if (csr_we) begin
            if (csr_index == CSR_CARD_PRESENT) card_present_q = csr_wdata[0];
            else card_size_q = csr_wdata;
         end
         // Responses are retired before new requests are predicted; a request
         // can never be answered at the edge that takes it.
         if (rsp_tvalid && rsp_tready) begin
            if (expected_responses.size() == 0) begin
               $display("%0t: response mismatch, expected none, actual read_data 0x%0h",
                        $time, rsp_tdata[31:0]);
               errors++;
            end else begin
               want = expected_responses.pop_front();
               check_field("read_data", 64'(want.read_data), 64'(rsp_tdata[31:0]));
               check_field("xfer_request", 64'(want.xfer_request), 64'(rsp_tuser));
               check_field("xfer_to_card", 64'(want.xfer_to_card), 64'(rsp_tdata[32]));
               check_field("xfer_byte_offset", 64'(want.xfer_byte_offset),
                           64'(rsp_tdata[73:33]));
               check_field("xfer_length_bytes", 64'(want.xfer_length_bytes),
                           64'(rsp_tdata[114:74]));
               check_field("xfer_mem_addr", 64'(want.xfer_mem_addr),
                           64'(rsp_tdata[143:115]));
               check_field("xfer_byteswap", 64'(want.xfer_byteswap), 64'(rsp_tdata[144]));
               check_field("zero fill", '0, 64'(rsp_tdata[151:145]));
            end
         end
         if (req_tvalid && req_tready) begin
            expected_responses.push_back(decode_access(req_tuser, req_tdata[15:0],
                                                       req_tdata[47:16] & req_tdata[79:48]));
         end
      end
      outstanding <= expected_responses.size();
   end

endmodule

FILE: dv/tb.sv
// ----------------------------------------------------------------------------
// Cartridge SD register interface testbench
// Drives bus accesses and configuration writes into the core, with random
// idle cycles on the request side and random stalls on the response side,
// while a checker predicts and compares every response.
// ----------------------------------------------------------------------------
module tb;
   import cartsd_pkg::*;

   // A command code that the block does not know, and an offset that maps
   // to no register.
   localparam logic [31:0] CMD_BOGUS    = 32'h0000_00FF;
   localparam logic [15:0] OFS_UNMAPPED = 16'hFFFF;

   localparam int RANDOM_PHASES   = 8;
   localparam int ITEMS_PER_PHASE = 110;

   logic                   clock;
   logic                   reset;
   logic                   req_tvalid;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata;
   logic                   req_tuser;
   logic                   rsp_tvalid;
   logic                   rsp_tready;
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   logic                   rsp_tuser;
   logic                   csr_we;
   logic                   csr_index;
   logic [31:0]            csr_wdata;

   int fail_count;
   int in_flight;

   // Idle and stall rates of the current phase, in percent of cycles.
   int sender_idle_pct = 0;
   int rsp_stall_pct   = 0;

   int sent_count = 0;

   // What the stimulus last wrote as the card size; used only to aim sector
   // numbers near the end of the card.
   logic [31:0] cur_size;

   cart_sd_register_interface_core dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   cartsd_access_checker u_checker (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .errors      (fail_count),
      .outstanding (in_flight)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // The response side stalls at random at the rate of the current phase.
   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(0, 99) >= rsp_stall_pct);
   end

   // Offers one access and returns at the edge where it is taken. The valid
   // stays high on return so that back-to-back transfers need no gap.
   task automatic send_raw(input logic wr, input logic [15:0] ofs,
                           input logic [31:0] wdata, input logic [31:0] wmask);
      while ($urandom_range(0, 99) < sender_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= wr;
      req_tdata  <= {wmask, wdata, ofs};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      sent_count++;
   endtask

   // Sends an access whose masked write value is v. Data and mask carry
   // random extra bits that cancel out, so every bit of both toggles.
   task automatic send_access(input logic wr, input logic [15:0] ofs, input logic [31:0] v);
      logic [31:0] noise;
      noise = $urandom;
      send_raw(wr, ofs, v | noise, v | ~noise);
   endtask

   // Stops offering requests and waits until every response has been taken.
   // The first edge lets the checker count the last request.
   task automatic drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (in_flight != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // Writes both configuration registers, the present flag first and then the size, on back-to-back edges.
   task automatic write_config(input logic present, input logic [31:0] size);
      logic [31:0] word;
      word      = $urandom;
      word[0]   = present;
      csr_we    <= 1'b1;
      csr_index <= CSR_CARD_PRESENT;
      csr_wdata <= word;
      @(posedge clock);
      csr_index <= CSR_CARD_SIZE;
      csr_wdata <= size;
      @(posedge clock);
      csr_we      <= 1'b0;
      cur_size    = size;
   endtask

   // One random piece of traffic. Most of it is a well-formed command
   // sequence (operands, command, status read); the rest is register reads,
   // unlock attempts, locking and raw noise at random offsets.
   task automatic random_sequence();
      int          pick;
      int          sel;
      logic [31:0] d0;
      logic [31:0] d1;
      logic [31:0] cmd;
      logic [15:0] ofs;
      pick = $urandom_range(0, 99);
      if (pick < 60) begin
         sel = $urandom_range(0, 99);
         d0  = $urandom;
         d1  = $urandom;
         if (sel < 40) begin
            cmd = $urandom_range(0, 1) ? CMD_SD_READ : CMD_SD_WRITE;
            // Memory address: mostly inside or just past one of the windows.
            case ($urandom_range(0, 4))
               0, 1: d0 = BUF_BASE + $urandom_range(0, $urandom_range(0, 1) ? 1023
                                                                            : BUFFER_BYTES_DEF);
               2, 3: d0 = ROM_BASE + $urandom_range(0, ROM_WINDOW_BYTES_DEF);
               default: ;
            endcase
            // The top three bits fall outside the 29-bit address.
            if ($urandom_range(0, 1)) d0[31:29] = 3'($urandom);
            case ($urandom_range(0, 9))
               0, 1, 2, 3, 4, 5: d1 = $urandom_range(0, 17);
               6, 7, 8:          d1 = $urandom_range(0, ROM_WINDOW_BYTES_DEF / 512 + 1);
               default:          ;
            endcase
         end else if (sel < 55) begin
            cmd = CMD_SECTOR;
            case ($urandom_range(0, 3))
               0, 1: d0 = $urandom_range(0, 15);
               2:    d0 = (cur_size >> 9) - $urandom_range(0, 2);
               default: ;
            endcase
         end else if (sel < 70) begin
            cmd = CMD_INIT;
            case ($urandom_range(0, 5))
               0: d1 = INIT_NOP;
               1: d1 = INIT_CARD;
               2: d1 = INIT_SWAP_ON;
               3: d1 = INIT_SWAP_OFF;
               4: d1 = $urandom_range(0, 7);
               default: ;
            endcase
         end else if (sel < 90) begin
            cmd = (sel < 80) ? CMD_CFG_GET : CMD_CFG_SET;
            case ($urandom_range(0, 4))
               0, 1: d0 = CFG_ROM_WRITE;
               2:    d0 = CFG_QUERY_A;
               3:    d0 = CFG_QUERY_B;
               default: d0 = $urandom_range(0, 7);
            endcase
            if ($urandom_range(0, 1)) d1 = $urandom_range(0, 1);
         end else begin
            cmd = $urandom;
         end
         // Operand writes are sometimes left out so that stale values are used.
         if ($urandom_range(0, 4) != 0) send_access(1'b1, OFS_DATA0, d0);
         if ($urandom_range(0, 4) != 0) send_access(1'b1, OFS_DATA1, d1);
         send_access(1'b1, OFS_STATUS, cmd);
         if ($urandom_range(0, 1)) send_access(1'b0, OFS_STATUS, '0);
         if ($urandom_range(0, 3) == 0) send_access(1'b0, OFS_DATA1, '0);
      end else if (pick < 78) begin
         send_access(1'b0, 16'($urandom_range(0, 3) * 4), '0);
      end else if (pick < 88) begin
         case ($urandom_range(0, 5))
            0: send_access(1'b1, OFS_UNLOCK, KEY_SECOND);
            1: begin
               send_access(1'b1, OFS_UNLOCK, KEY_FIRST);
               send_access(1'b1, OFS_UNLOCK, $urandom);
               send_access(1'b1, OFS_UNLOCK, KEY_SECOND);
            end
            2: begin
               // A lock between the two keys leaves the first key armed.
               send_access(1'b1, OFS_UNLOCK, KEY_FIRST);
               send_access(1'b1, OFS_UNLOCK, KEY_LOCK);
               send_access(1'b1, OFS_UNLOCK, KEY_SECOND);
            end
            default: begin
               send_access(1'b1, OFS_UNLOCK, KEY_FIRST);
               send_access(1'b1, OFS_UNLOCK, KEY_SECOND);
            end
         endcase
      end else if (pick < 91) begin
         send_access(1'b1, OFS_UNLOCK, KEY_LOCK);
      end else begin
         // Raw noise, either anywhere in the offset space or near the map.
         ofs = $urandom_range(0, 1) ? 16'($urandom) : 16'($urandom_range(0, 5) * 4);
         send_raw(1'($urandom_range(0, 1)), ofs, $urandom, $urandom);
      end
   endtask

   initial begin
      int goal;
      // Every input is known from time zero.
      reset       = 1'b1;
      req_tvalid  = 1'b0;
      req_tdata   = '0;
      req_tuser   = 1'b0;
      rsp_tready  = 1'b0;
      csr_we      = 1'b0;
      csr_index   = CSR_CARD_PRESENT;
      csr_wdata   = '0;
      cur_size    = '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // Directed part, first with no card present and a zero-size card.
      write_config(1'b0, 32'h0);
      send_access(1'b0, OFS_ID, '0);             // locked read returns zero
      send_access(1'b1, OFS_UNLOCK, KEY_SECOND); // second key alone does nothing
      send_access(1'b1, OFS_UNLOCK, KEY_FIRST);
      send_access(1'b1, OFS_UNLOCK, '0);         // another value disarms the first key
      send_access(1'b1, OFS_UNLOCK, KEY_SECOND); // so this one still does nothing
      send_access(1'b1, OFS_UNLOCK, KEY_FIRST);
      send_access(1'b1, OFS_UNLOCK, KEY_SECOND); // unlocked now
      send_access(1'b1, OFS_DATA1, INIT_CARD);
      send_access(1'b1, OFS_STATUS, CMD_INIT);   // init without a card is an error
      send_access(1'b0, OFS_STATUS, '0);
      drain();

      // Then with a card of the largest size.
      write_config(1'b1, 32'hFFFF_FFFF);
      send_access(1'b1, OFS_STATUS, CMD_INIT);   // opens the card
      send_access(1'b1, OFS_DATA0, BUF_BASE | 32'hE000_0000);
      send_access(1'b1, OFS_DATA1, 32'd16);
      send_access(1'b1, OFS_STATUS, CMD_SD_READ); // ends exactly at the buffer limit
      send_access(1'b1, OFS_DATA1, 32'd15);
      send_access(1'b1, OFS_STATUS, CMD_SD_WRITE); // fits the buffer window
      send_access(1'b1, OFS_DATA0, 32'hFFFF_FFFF);
      send_access(1'b1, OFS_STATUS, CMD_SECTOR);   // largest sector number
      send_access(1'b1, OFS_STATUS, CMD_SD_READ);  // runs past the card end
      send_access(1'b1, OFS_STATUS, CMD_BOGUS);
      send_access(1'b0, OFS_UNMAPPED, '0);
      send_access(1'b1, OFS_UNLOCK, KEY_LOCK);
      send_access(1'b0, OFS_ID, '0);
      send_access(1'b1, OFS_UNLOCK, KEY_FIRST);
      send_access(1'b1, OFS_UNLOCK, KEY_SECOND);

      // Random phases. Each one changes the configuration while the block is
      // idle and picks one of the idle and stall patterns.
      for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
         drain();
         case (ph)
            0: write_config(1'b1, 32'hFFFF_FFFF);
            1: write_config(1'b1, $urandom);
            2: write_config(1'b0, $urandom);
            3: write_config(1'b1, 32'h0010_0000);
            4: write_config(1'b1, 32'h0);
            5: write_config(1'b0, 32'hFFFF_FFFF);
            6: write_config(1'b1, $urandom);
            default: write_config(1'b1, 32'hFFFF_FFFF);
         endcase
         case (ph % 4)
            0: begin
               sender_idle_pct = 0;
               rsp_stall_pct   = 0;
            end
            1: begin
               sender_idle_pct = 76;
               rsp_stall_pct   = 0;
            end
            2: begin
               sender_idle_pct = 0;
               rsp_stall_pct   = 76;
            end
            default: begin
               sender_idle_pct = 15;
               rsp_stall_pct   = 15;
            end
         endcase
         // Start each phase unlocked and with the card state matching the
         // new configuration.
         send_access(1'b1, OFS_UNLOCK, KEY_FIRST);
         send_access(1'b1, OFS_UNLOCK, KEY_SECOND);
         send_access(1'b1, OFS_DATA1, INIT_CARD);
         send_access(1'b1, OFS_STATUS, CMD_INIT);
         goal = sent_count + ITEMS_PER_PHASE;
         while (sent_count < goal) random_sequence();
      end

      drain();
      if (fail_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

   // Watchdog, far beyond the slowest correct run.
   initial begin
      #5_000_000;
      $display("Simulation FAILED");
      $finish;
   end

endmodule
